>>> sv/jacobi_linear_solver_macros.svh
// Assertion macros used by jacobi_linear_solver.sv, the file that checks this block.
`ifndef JACOBI_LINEAR_SOLVER_MACROS_SVH
`define JACOBI_LINEAR_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define JLS_ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("jacobi_linear_solver assertion failed");
`define JLS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("jacobi_linear_solver assertion failed");
`else
`define JLS_ASSERT_IMPLIES(label, clk, rst, a, c)
`define JLS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

>>> sv/jls_pkg.sv
`timescale 1ns / 1ps
package jls_pkg;
  localparam int MAX_EQUATIONS = 8;
  localparam int STORE_COLS = MAX_EQUATIONS + 1;
  localparam int STORE_DEPTH = MAX_EQUATIONS * STORE_COLS;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int IDX_W = 3;
  localparam int COL_W = 4;
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int ACC_W = 52;
  localparam int CLAMP_BIT = 47;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int EQ_W = 4;
  localparam int ITER_W = 6;
  localparam int CFG_W = 6;

  localparam logic CFG_EQUATION_COUNT = 1'b0;
  localparam logic CFG_MAX_ITERATIONS = 1'b1;

  localparam logic [1:0] STATUS_CONVERGED = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DIAG = 2'd1;
  localparam logic [1:0] STATUS_LIMIT = 2'd2;

  localparam logic [EQ_W-1:0] EQ_RESET = 4'd3;
  localparam logic [ITER_W-1:0] ITER_RESET = 6'd10;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [COL_W-1:0] column;
    logic signed [DATA_W-1:0] coefficient;
    logic start_solve;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] unknown_index;
    logic signed [DATA_W-1:0] estimate;
    logic [ITER_W-1:0] sweeps_done;
    logic [1:0] status;
    logic last_result;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] raddr;
    logic [IDX_W-1:0] row_idx;
    logic [IDX_W-1:0] col_idx;
    logic acc_clr;
    logic mul_en;
    logic acc_en;
    logic num_en;
    logic div_start;
    logic est_write;
    logic est_copy;
    logic est_clear;
    logic emit;
    logic last;
    logic [1:0] status;
    logic [ITER_W-1:0] sweeps;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_equal;
    logic diag_zero;
  } sts_t;

  function automatic logic [ADDR_W-1:0] store_addr(logic [IDX_W-1:0] r, logic [COL_W-1:0] c);
    store_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(STORE_COLS) + ADDR_W'(c));
  endfunction
endpackage

>>> sv/jls_ram.sv
`timescale 1ns / 1ps
module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 72
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/jls_div.sv
`timescale 1ns / 1ps
module jls_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [jls_pkg::ACC_W-1:0] num,
  input  logic signed [jls_pkg::DATA_W-1:0] den,
  output logic done,
  output logic signed [jls_pkg::DATA_W-1:0] quot
);
  import jls_pkg::*;

  localparam logic [ACC_W-1:0] CLAMP = ACC_W'(1) << CLAMP_BIT;

  logic busy;
  logic neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0] dm;
  logic [DATA_W-1:0] rem;
  logic [PROD_W-1:0] dvd;
  logic [ACC_W-1:0] num_abs;
  logic [CLAMP_BIT:0] mag;
  logic [DATA_W:0] rem_sh;
  logic ge;
  logic [DATA_W-1:0] rem_next;

  always_comb begin
    num_abs = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    mag = (num_abs > CLAMP) ? CLAMP[CLAMP_BIT:0] : num_abs[CLAMP_BIT:0];
    rem_sh = {rem, dvd[PROD_W-1]};
    ge = rem_sh >= {1'b0, dm};
    rem_next = ge ? DATA_W'(rem_sh - {1'b0, dm}) : rem_sh[DATA_W-1:0];
    if (neg) begin
      quot = (|dvd[PROD_W-1:DATA_W-1]) ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : DATA_W'(-dvd[DATA_W-1:0]);
    end else begin
      quot = (|dvd[PROD_W-1:DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}}
                                       : dvd[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= num[ACC_W-1] ^ den[DATA_W-1];
        dm <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
        rem <= '0;
        dvd <= {mag[PROD_W-17:0], 16'b0};
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[PROD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/jls_datapath.sv
`timescale 1ns / 1ps
module jls_datapath (
  input  logic clk,
  input  logic rst,
  input  jls_pkg::cmd_t cmd,
  input  logic [jls_pkg::DATA_W-1:0] rdata,
  output jls_pkg::sts_t sts,
  output jls_pkg::out_t result,
  output logic result_strobe
);
  import jls_pkg::*;

  logic signed [DATA_W-1:0] new_est [MAX_EQUATIONS];
  logic signed [DATA_W-1:0] old_est [MAX_EQUATIONS];
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] num;
  logic signed [DATA_W-1:0] quot;
  logic div_done;

  jls_div u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .num(num),
    .den(rdata),
    .done(div_done),
    .quot(quot)
  );

  always_comb begin
    prod_sh = prod >>> 16;
    sts.div_done = div_done;
    sts.last_equal = quot == old_est[cmd.row_idx];
    sts.diag_zero = rdata == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      for (int i = 0; i < MAX_EQUATIONS; i++) begin
        new_est[i] <= '0;
        old_est[i] <= '0;
      end
    end else begin
      result_strobe <= cmd.emit;
      for (int i = 0; i < MAX_EQUATIONS; i++) begin
        if (cmd.est_clear) begin
          new_est[i] <= '0;
          old_est[i] <= '0;
        end else begin
          if (cmd.est_write && cmd.row_idx == IDX_W'(i)) begin
            new_est[i] <= quot;
          end
          if (cmd.est_copy) begin
            old_est[i] <= (cmd.est_write && cmd.row_idx == IDX_W'(i)) ? quot : new_est[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= $signed(rdata) * old_est[cmd.col_idx];
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + ACC_W'(prod_sh);
    end
    if (cmd.num_en) begin
      num <= ACC_W'($signed(rdata)) - acc;
    end
    if (cmd.emit) begin
      result.unknown_index <= cmd.row_idx;
      result.estimate <= new_est[cmd.row_idx];
      result.sweeps_done <= cmd.sweeps;
      result.status <= cmd.status;
      result.last_result <= cmd.last;
    end
  end
endmodule

>>> sv/jls_ctrl.sv
`timescale 1ns / 1ps
module jls_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic solve_req,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [jls_pkg::CFG_W-1:0] cfg_data,
  input  jls_pkg::sts_t sts,
  output jls_pkg::cmd_t cmd,
  output logic busy
);
  import jls_pkg::*;

  typedef enum logic [3:0] {
    IDLE, CHK_RD, CHK_EV, ROW, MAC_RD, MAC_MUL, MAC_ACC,
    RHS_RD, DIAG_RD, DIV_GO, DIV_WAIT, EMIT
  } state_t;

  state_t state;
  logic [EQ_W-1:0] equation_count;
  logic [ITER_W-1:0] max_iterations;
  logic [IDX_W-1:0] n;
  logic [IDX_W-1:0] m;
  logic [ITER_W-1:0] sweep;
  logic [1:0] status;
  logic zdiag;
  logic [EQ_W-1:0] n_eq;
  logic [IDX_W-1:0] n_last;
  logic [ITER_W-1:0] limit;
  logic [COL_W-1:0] rd_col;

  always_comb begin
    if (equation_count == '0) begin
      n_eq = EQ_W'(1);
    end else if (equation_count > EQ_W'(MAX_EQUATIONS)) begin
      n_eq = EQ_W'(MAX_EQUATIONS);
    end else begin
      n_eq = equation_count;
    end
    n_last = IDX_W'(n_eq - 1'b1);
    limit = (max_iterations == '0) ? ITER_W'(1) : max_iterations;
    case (state)
      MAC_RD:  rd_col = COL_W'(m);
      RHS_RD:  rd_col = n_eq;
      default: rd_col = COL_W'(n);
    endcase
    busy = state != IDLE;
    cmd = '0;
    cmd.raddr = store_addr(n, rd_col);
    cmd.row_idx = n;
    cmd.col_idx = m;
    cmd.acc_clr = state == ROW;
    cmd.mul_en = state == MAC_MUL;
    cmd.acc_en = state == MAC_ACC;
    cmd.num_en = state == DIAG_RD;
    cmd.div_start = state == DIV_GO;
    cmd.est_write = state == DIV_WAIT && sts.div_done;
    cmd.est_copy = state == DIV_WAIT && sts.div_done && n == n_last && !sts.last_equal
                   && ITER_W'(sweep + 1'b1) < limit;
    cmd.est_clear = state == IDLE && solve_req;
    cmd.emit = state == EMIT;
    cmd.last = n == n_last;
    cmd.status = status;
    cmd.sweeps = sweep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      equation_count <= EQ_RESET;
      max_iterations <= ITER_RESET;
      n <= '0;
      m <= '0;
      sweep <= '0;
      status <= STATUS_CONVERGED;
      zdiag <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_EQUATION_COUNT: equation_count <= cfg_data[EQ_W-1:0];
          CFG_MAX_ITERATIONS: max_iterations <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          if (solve_req) begin
            n <= '0;
            sweep <= '0;
            zdiag <= 1'b0;
            state <= CHK_RD;
          end
        end
        CHK_RD: state <= CHK_EV;
        CHK_EV: begin
          if (n == n_last) begin
            n <= '0;
            if (zdiag || sts.diag_zero) begin
              status <= STATUS_ZERO_DIAG;
              state <= EMIT;
            end else begin
              state <= ROW;
            end
          end else begin
            zdiag <= zdiag | sts.diag_zero;
            n <= n + 1'b1;
            state <= CHK_RD;
          end
        end
        ROW: begin
          m <= '0;
          state <= MAC_RD;
        end
        MAC_RD: begin
          if (m == n) begin
            if (m == n_last) begin
              state <= RHS_RD;
            end else begin
              m <= m + 1'b1;
            end
          end else begin
            state <= MAC_MUL;
          end
        end
        MAC_MUL: state <= MAC_ACC;
        MAC_ACC: begin
          if (m == n_last) begin
            state <= RHS_RD;
          end else begin
            m <= m + 1'b1;
            state <= MAC_RD;
          end
        end
        RHS_RD: state <= DIAG_RD;
        DIAG_RD: state <= DIV_GO;
        DIV_GO: state <= DIV_WAIT;
        DIV_WAIT: begin
          if (sts.div_done) begin
            if (n == n_last) begin
              sweep <= sweep + 1'b1;
              n <= '0;
              if (sts.last_equal) begin
                status <= STATUS_CONVERGED;
                state <= EMIT;
              end else if (ITER_W'(sweep + 1'b1) >= limit) begin
                status <= STATUS_LIMIT;
                state <= EMIT;
              end else begin
                state <= ROW;
              end
            end else begin
              n <= n + 1'b1;
              state <= ROW;
            end
          end
        end
        EMIT: begin
          if (n == n_last) begin
            n <= '0;
            state <= IDLE;
          end else begin
            n <= n + 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

>>> sv/jacobi_linear_solver.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     start / busy          item (row, column, coefficient, start_solve)
// result    result_strobe         result (one word per unknown, index order)
// config    cfg_write             cfg_index, cfg_data
//
// A coefficient word is stored when accepted; a word with start_solve begins a solve.
// A solve first checks the N diagonal entries, then runs sweeps of N rows, each row
// using the serial multiply-accumulate and the 64-step divider.
// The N result words follow back to back; busy falls as the last one is presented.
// Reset is synchronous; results cannot be stalled by the receiver.
`include "jacobi_linear_solver_macros.svh"
module jacobi_linear_solver (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  jls_pkg::in_t item,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [jls_pkg::CFG_W-1:0] cfg_data,
  output jls_pkg::out_t result,
  output logic result_strobe
);
  import jls_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic accept;
  logic store_we;
  logic [DATA_W-1:0] rdata;

  assign accept = start && !busy;
  assign store_we = accept && item.column <= COL_W'(MAX_EQUATIONS);

  jls_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk(clk),
    .we(store_we),
    .waddr(store_addr(item.row, item.column)),
    .wdata(item.coefficient),
    .raddr(cmd.raddr),
    .rdata(rdata)
  );

  jls_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .solve_req(accept && item.start_solve),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sts(sts),
    .cmd(cmd),
    .busy(busy)
  );

  jls_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rdata(rdata),
    .sts(sts),
    .result(result),
    .result_strobe(result_strobe)
  );

  `JLS_ASSERT_NEXT(solve_sets_busy, clk, rst, accept && item.start_solve, busy)
  `JLS_ASSERT_NEXT(last_word_ends_run, clk, rst, result_strobe && result.last_result,
    !result_strobe)
  `JLS_ASSERT_NEXT(div_not_instant, clk, rst, cmd.div_start, !sts.div_done)
endmodule
